// ----- rtl/front_coded_string_decoder_core_assert.svh -----
// Assertion macros for the front-coded string decoder.
// Included by the top level; no other dependencies.
`ifndef FRONT_CODED_STRING_DECODER_CORE_ASSERT_SVH
`define FRONT_CODED_STRING_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
`define FCSD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fcsd: implication check failed");
`define FCSD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fcsd: next-cycle check failed");
`else
`define FCSD_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define FCSD_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/fcsd_pkg.sv -----
// Shared types and constants for the front-coded string decoder.
// No dependencies; used by every module of the block but fcsd_ram.
package fcsd_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = 7;

    // Queue depths must be powers of two (pointers wrap freely).
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;
    localparam int O_DEPTH = 4;
    localparam int O_PTR_W = $clog2(O_DEPTH);
    localparam int O_CNT_W = O_PTR_W + 1;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_PREFIX = 2'd1,
        ERR_LENGTH = 2'd2,
        ERR_STRAY  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        OP_ERROR  = 2'd0,
        OP_EMPTY  = 2'd1,
        OP_PREFIX = 2'd2,
        OP_BYTE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [7:0]        data;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  count;
        logic              last;
        logic [LEN_W-1:0]  total;
        err_t              err;
    } cmd_t;

    typedef struct packed {
        logic               full;
        logic               valid;
        logic [Q_CNT_W-1:0] count;
    } qstat_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             value_end;
        logic             empty_value;
        logic [LEN_W-1:0] value_length;
        err_t             error_code;
    } res_t;

endpackage

// ----- rtl/fcsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- rtl/fcsd_front.sv -----
// Front end: accepts input beats, checks them against the value state
// and turns them into commands for the back end. Depends on fcsd_pkg.
module fcsd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [1:0]      kind,
    input  logic [15:0]     prefix_len,
    input  logic [15:0]     suffix_len,
    input  logic [7:0]      data_byte,
    input  fcsd_pkg::qstat_t q_stat,
    output logic            cmd_push,
    output fcsd_pkg::cmd_t  cmd
);
    import fcsd_pkg::*;

    logic [LEN_W-1:0] prev_len_reg, prev_len_next;
    logic [LEN_W-1:0] wpos_reg, wpos_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] vlen_reg, vlen_next;
    logic             accept;
    logic             want_push;
    logic [16:0]      total;
    logic             prefix_bad;

    assign full       = q_stat.full;
    assign accept     = push && !q_stat.full;
    assign total      = {1'b0, prefix_len} + {1'b0, suffix_len};
    assign prefix_bad = prefix_len > {{(16-LEN_W){1'b0}}, prev_len_reg};
    assign cmd_push   = accept && want_push;

    always_comb
    begin
        prev_len_next = prev_len_reg;
        wpos_next     = wpos_reg;
        rem_next      = rem_reg;
        vlen_next     = vlen_reg;
        want_push     = 1'b0;
        cmd           = '0;
        cmd.op        = OP_ERROR;
        cmd.err       = ERR_NONE;
        case (kind)
            KIND_HEADER:
            begin
                want_push = 1'b1;
                if (rem_reg != '0)
                begin
                    cmd.err = ERR_STRAY;
                end
                else if (prefix_bad)
                begin
                    cmd.err = ERR_PREFIX;
                end
                else if (total > 17'(MAX_LEN))
                begin
                    cmd.err = ERR_LENGTH;
                end
                else if (total == '0)
                begin
                    cmd.op        = OP_EMPTY;
                    prev_len_next = '0;
                    wpos_next     = '0;
                    vlen_next     = '0;
                end
                else
                begin
                    // A header with no prefix emits nothing by itself.
                    want_push = (prefix_len != '0);
                    cmd.op    = OP_PREFIX;
                    cmd.count = prefix_len[LEN_W-1:0];
                    cmd.last  = (suffix_len == '0);
                    cmd.total = total[LEN_W-1:0];
                    wpos_next = prefix_len[LEN_W-1:0];
                    rem_next  = suffix_len[LEN_W-1:0];
                    vlen_next = total[LEN_W-1:0];
                    if (suffix_len == '0)
                    begin
                        prev_len_next = total[LEN_W-1:0];
                    end
                end
            end
            KIND_DATA:
            begin
                want_push = 1'b1;
                if (rem_reg == '0)
                begin
                    cmd.err = ERR_STRAY;
                end
                else
                begin
                    cmd.op    = OP_BYTE;
                    cmd.data  = data_byte;
                    cmd.addr  = wpos_reg[ADDR_W-1:0];
                    cmd.last  = (rem_reg == LEN_W'(1));
                    cmd.total = vlen_reg;
                    wpos_next = wpos_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    if (rem_reg == LEN_W'(1))
                    begin
                        prev_len_next = vlen_reg;
                    end
                end
            end
            KIND_RESTART:
            begin
                prev_len_next = '0;
                wpos_next     = '0;
                rem_next      = '0;
                vlen_next     = '0;
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_len_reg <= '0;
            wpos_reg     <= '0;
            rem_reg      <= '0;
            vlen_reg     <= '0;
        end
        else if (accept)
        begin
            prev_len_reg <= prev_len_next;
            wpos_reg     <= wpos_next;
            rem_reg      <= rem_next;
            vlen_reg     <= vlen_next;
        end
    end
endmodule

// ----- rtl/fcsd_queue.sv -----
// Command queue between front and back end.
// Depends on fcsd_pkg.
module fcsd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fcsd_pkg::cmd_t   din,
    input  logic             pop,
    output fcsd_pkg::cmd_t   dout,
    output fcsd_pkg::qstat_t stat
);
    import fcsd_pkg::*;

    cmd_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] head_reg, head_next;
    logic [Q_PTR_W-1:0] tail_reg, tail_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.valid = (count_reg != '0);
    assign stat.count = count_reg;
    assign dout       = mem[head_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;

    always_comb
    begin
        head_next  = do_pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = do_push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= din;
        end
    end
endmodule

// ----- rtl/fcsd_back.sv -----
// Back end: executes commands against the value store and queues results.
// Depends on fcsd_pkg and fcsd_ram.
module fcsd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  fcsd_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output fcsd_pkg::res_t res,
    output logic           res_empty,
    input  logic           res_pop
);
    import fcsd_pkg::*;

    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               s2_valid_reg;
    logic               s2_ram_reg;
    res_t               s2_res_reg, s2_res_next;
    logic [7:0]         ram_rdata;
    res_t               s2_out;
    res_t               omem [O_DEPTH];
    logic [O_PTR_W-1:0] ohead_reg, otail_reg;
    logic [O_CNT_W-1:0] ocount_reg, ocount_next;
    logic               room;
    logic               issue;
    logic               prefix_last;
    logic               is_prefix;
    logic               do_opop;

    // Count the beat in the read stage as taken so nothing overflows.
    assign room        = ({1'b0, ocount_reg} + {{O_CNT_W{1'b0}}, s2_valid_reg})
                         < (O_CNT_W + 1)'(O_DEPTH);
    assign issue       = cmd_valid && room;
    assign is_prefix   = (cmd.op == OP_PREFIX);
    assign prefix_last = ({1'b0, idx_reg} + 1'b1) == cmd.count;
    assign cmd_pop     = issue && (!is_prefix || prefix_last);

    fcsd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (issue && (cmd.op == OP_BYTE)),
        .waddr (cmd.addr),
        .wdata (cmd.data),
        .re    (issue && is_prefix),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s2_res_next            = '0;
        s2_res_next.error_code = ERR_NONE;
        idx_next               = idx_reg;
        case (cmd.op)
            OP_ERROR:
            begin
                s2_res_next.error_code = cmd.err;
            end
            OP_EMPTY:
            begin
                s2_res_next.value_end   = 1'b1;
                s2_res_next.empty_value = 1'b1;
            end
            OP_PREFIX:
            begin
                s2_res_next.value_end = prefix_last && cmd.last;
                if (prefix_last && cmd.last)
                begin
                    s2_res_next.value_length = cmd.total;
                end
                if (issue)
                begin
                    idx_next = prefix_last ? '0 : idx_reg + 1'b1;
                end
            end
            OP_BYTE:
            begin
                s2_res_next.out_byte  = cmd.data;
                s2_res_next.value_end = cmd.last;
                if (cmd.last)
                begin
                    s2_res_next.value_length = cmd.total;
                end
            end
            default:
            begin
                s2_res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        s2_out = s2_res_reg;
        if (s2_ram_reg)
        begin
            s2_out.out_byte = ram_rdata;
        end
    end

    assign res_empty = (ocount_reg == '0);
    assign res       = omem[ohead_reg];
    assign do_opop   = res_pop && !res_empty;

    always_comb
    begin
        case ({s2_valid_reg, do_opop})
            2'b10:   ocount_next = ocount_reg + 1'b1;
            2'b01:   ocount_next = ocount_reg - 1'b1;
            default: ocount_next = ocount_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s2_valid_reg <= 1'b0;
            s2_ram_reg   <= 1'b0;
            ohead_reg    <= '0;
            otail_reg    <= '0;
            ocount_reg   <= '0;
        end
        else
        begin
            idx_reg      <= idx_next;
            s2_valid_reg <= issue;
            s2_ram_reg   <= issue && is_prefix;
            ocount_reg   <= ocount_next;
            if (s2_valid_reg)
            begin
                otail_reg <= otail_reg + 1'b1;
            end
            if (do_opop)
            begin
                ohead_reg <= ohead_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_res_reg <= s2_res_next;
        end
        if (s2_valid_reg)
        begin
            omem[otail_reg] <= s2_out;
        end
    end
endmodule

// ----- rtl/front_coded_string_decoder_core.sv -----
// Top level of the front-coded string decoder.
// Depends on fcsd_pkg, fcsd_front, fcsd_queue, fcsd_back and the assert header.
//
//  channel  | handshake    | payload
//  ---------+--------------+--------------------------------------------------
//  input    | push / full  | kind, prefix_len, suffix_len, data_byte
//  result   | pop / empty  | out_byte, value_end, empty_value, value_length,
//           |              | error_code
//
// The front end turns each input beat into at most one command; the back end
// gives one result for a suffix byte, error or empty value and n results for
// an n-byte prefix, one store read each. Results pass the command queue, the
// read stage register and the result queue. Reset clears all control state; the
// value store needs no clearing pass. Input stalls when the four-entry command
// queue fills; the back end stalls when the four-entry result queue has no room.
`include "front_coded_string_decoder_core_assert.svh"

module front_coded_string_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] prefix_len,
    input  logic [15:0] suffix_len,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        value_end,
    output logic        empty_value,
    output logic [6:0]  value_length,
    output logic [1:0]  error_code
);
    import fcsd_pkg::*;

    qstat_t q_stat;
    logic   cmd_push;
    cmd_t   cmd_in;
    cmd_t   cmd_head;
    logic   cmd_pop;
    res_t   res;

    // Classify each beat and track the value being built.
    fcsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .prefix_len (prefix_len),
        .suffix_len (suffix_len),
        .data_byte  (data_byte),
        .q_stat     (q_stat),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    // Decouple acceptance from execution.
    fcsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .stat  (q_stat)
    );

    // Replay prefixes from the store, write suffix bytes, queue results.
    fcsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_stat.valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign out_byte     = res.out_byte;
    assign value_end    = res.value_end;
    assign empty_value  = res.empty_value;
    assign value_length = res.value_length;
    assign error_code   = res.error_code;

    // A closing result never carries an error.
    `FCSD_ASSERT_IMP(a_end_no_error, clk, rst_n, !empty && value_end, error_code == ERR_NONE)
    // An empty value is a single closing result of length zero.
    `FCSD_ASSERT_IMP(a_empty_shape, clk, rst_n, !empty && empty_value,
                     value_end && (value_length == '0))
    // The front end only pushes when the command queue has room.
    `FCSD_ASSERT_IMP(a_no_queue_overrun, clk, rst_n, cmd_push, !q_stat.full)
    // A full command queue stays full until the back end takes a command.
    `FCSD_ASSERT_NXT(a_full_then_count, clk, rst_n, q_stat.full && !cmd_pop,
                     q_stat.full)
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for front_coded_string_decoder_core: directed and random beats
// are checked against an in-bench model of the decoder.
// Depends on fcsd_pkg and the decoder RTL; reads no files.

module tb_top;
    import fcsd_pkg::*;

    // Kind code the block has to ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_BEATS  = 200;
    localparam int QUIET_TAIL    = 30;     // last beats start no random idle bursts
    localparam int SETTLE_CYCLES = 20;     // results trail their beat through the block's queues
    localparam int DRAIN_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] prefix_len;
        logic [15:0] suffix_len;
        logic [7:0]  data_byte;
        bit          wait_drain;   // hold this beat until every expected result is back
    } coded_beat_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block itself
    // ------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic [1:0]  kind       = '0;
    logic [15:0] prefix_len = '0;
    logic [15:0] suffix_len = '0;
    logic [7:0]  data_byte  = '0;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  out_byte;
    logic        value_end;
    logic        empty_value;
    logic [6:0]  value_length;
    logic [1:0]  error_code;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    front_coded_string_decoder_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .prefix_len   (prefix_len),
        .suffix_len   (suffix_len),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .value_end    (value_end),
        .empty_value  (empty_value),
        .value_length (value_length),
        .error_code   (error_code)
    );

    // ------------------------------------------------------------------
    // Decoder model: its own copy of the stored value and the counters.
    // Each accepted beat appends the results it expects to rebuilt_q.
    // ------------------------------------------------------------------
    logic [7:0]       last_value [MAX_LEN];
    logic [LEN_W-1:0] last_len   = '0;   // length of the latest complete value
    logic [LEN_W-1:0] wr_pos     = '0;
    logic [LEN_W-1:0] bytes_owed = '0;   // suffix bytes still to come
    logic [LEN_W-1:0] cur_total  = '0;   // length of the value being built

    res_t        rebuilt_q [$];
    coded_beat_t coded_beats [$];
    int          fail_cnt = 0;

    function automatic res_t make_res(input logic [7:0] b, input bit fin, input bit zero_len,
                                      input int unsigned len, input err_t code);
        res_t r;
        r.out_byte     = b;
        r.value_end    = fin;
        r.empty_value  = zero_len;
        r.value_length = LEN_W'(len);
        r.error_code   = code;
        return r;
    endfunction

    task automatic rebuild_step(input coded_beat_t b);
        int unsigned total;
        bit          fin;
        total = int'(b.prefix_len) + int'(b.suffix_len);
        case (b.kind)
            KIND_HEADER:
            begin
                // Order of the checks matters: open value first, then prefix, then length
                if (bytes_owed != 0)
                    rebuilt_q.push_back(make_res(8'h00, 1'b0, 1'b0, 0, ERR_STRAY));
                else if (b.prefix_len > last_len)
                    rebuilt_q.push_back(make_res(8'h00, 1'b0, 1'b0, 0, ERR_PREFIX));
                else if (total > MAX_LEN)
                    rebuilt_q.push_back(make_res(8'h00, 1'b0, 1'b0, 0, ERR_LENGTH));
                else if (total == 0)
                begin
                    rebuilt_q.push_back(make_res(8'h00, 1'b1, 1'b1, 0, ERR_NONE));
                    last_len  = '0;
                    wr_pos    = '0;
                    cur_total = '0;
                end
                else
                begin
                    // Replay the shared prefix out of the stored value
                    for (int i = 0; i < int'(b.prefix_len); i++)
                    begin
                        fin = (i + 1 == int'(b.prefix_len)) && (b.suffix_len == 0);
                        rebuilt_q.push_back(make_res(last_value[i], fin, 1'b0,
                                                     fin ? total : 0, ERR_NONE));
                    end
                    wr_pos     = LEN_W'(b.prefix_len);
                    bytes_owed = LEN_W'(b.suffix_len);
                    cur_total  = LEN_W'(total);
                    if (b.suffix_len == 0)
                        last_len = LEN_W'(total);
                end
            end
            KIND_DATA:
            begin
                if (bytes_owed == 0)
                    rebuilt_q.push_back(make_res(8'h00, 1'b0, 1'b0, 0, ERR_STRAY));
                else
                begin
                    last_value[wr_pos] = b.data_byte;
                    wr_pos++;
                    bytes_owed--;
                    fin = (bytes_owed == 0);
                    rebuilt_q.push_back(make_res(b.data_byte, fin, 1'b0,
                                                 fin ? int'(cur_total) : 0, ERR_NONE));
                    // Only a finished value becomes the new prefix source
                    if (fin)
                        last_len = cur_total;
                end
            end
            KIND_RESTART:
            begin
                last_len   = '0;
                wr_pos     = '0;
                bytes_owed = '0;
                cur_total  = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders. gen_prev_len tracks the length of the last complete
    // value so that random headers can be made well formed.
    // ------------------------------------------------------------------
    int beat_total    = 0;
    int gen_prev_len  = 0;
    bit drain_pending = 1'b0;

    task automatic add_beat(input logic [1:0] k, input int unsigned p, input int unsigned s,
                            input int unsigned d);
        coded_beat_t b;
        b.kind       = k;
        b.prefix_len = 16'(p);
        b.suffix_len = 16'(s);
        b.data_byte  = 8'(d);
        b.wait_drain = drain_pending;
        drain_pending = 1'b0;
        coded_beats.push_back(b);
        if (k != KIND_UNUSED)
            beat_total++;
    endtask

    task automatic add_header(input int unsigned p, input int unsigned s);
        add_beat(KIND_HEADER, p, s, $urandom_range(0, 255));
    endtask

    task automatic add_bytes(input int n);
        repeat (n)
            add_beat(KIND_DATA, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 255));
    endtask

    task automatic add_value(input int p, input int s);
        add_header(p, s);
        add_bytes(s);
        gen_prev_len = p + s;
    endtask

    // Mostly short values; now and then a long one, sometimes a full MAX_LEN
    task automatic pick_value(output int p, output int s);
        int cap;
        if ($urandom_range(0, 11) == 0)
        begin
            p = $urandom_range(0, gen_prev_len);
            s = ($urandom_range(0, 1) == 0) ? MAX_LEN - p : $urandom_range(0, MAX_LEN - p);
        end
        else
        begin
            cap = (gen_prev_len < 6) ? gen_prev_len : 6;
            p = $urandom_range(0, cap);
            s = $urandom_range(0, 6);
        end
    endtask

    // Same, but at least one suffix byte so the value can be interrupted
    task automatic pick_open_value(output int p, output int s);
        pick_value(p, s);
        if (s == 0)
        begin
            s = 1;
            if (p + s > MAX_LEN)
                p--;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present one beat at a time from coded_beats, idle in bursts
    // ------------------------------------------------------------------
    coded_beat_t cur_beat;
    int          drv_idle   = 0;
    bit          drv_smooth = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        bit taken;
        if (!rst_n)
        begin
            push       <= 1'b0;
            kind       <= '0;
            prefix_len <= '0;
            suffix_len <= '0;
            data_byte  <= '0;
            drv_idle   = 0;
        end
        else
        begin
            taken = push && !full;
            if (taken)
                rebuild_step(cur_beat);

            if (push && !taken)
            begin
                // hold the beat until the block takes it
            end
            else if (drv_idle > 0)
            begin
                drv_idle--;
                push <= 1'b0;
            end
            else if (coded_beats.size() == 0)
                push <= 1'b0;
            else if (coded_beats[0].wait_drain && rebuilt_q.size() != 0)
                push <= 1'b0;   // hold off until the block has drained
            else if (!drv_smooth && coded_beats.size() > QUIET_TAIL &&
                     $urandom_range(0, 5) == 0)
            begin
                drv_idle = $urandom_range(0, 18);   // start an idle burst of random length
                push <= 1'b0;
            end
            else
            begin
                cur_beat = coded_beats.pop_front();
                push       <= 1'b1;
                kind       <= cur_beat.kind;
                prefix_len <= cur_beat.prefix_len;
                suffix_len <= cur_beat.suffix_len;
                data_byte  <= cur_beat.data_byte;
            end

            // Flip between bursty and steady stretches now and then
            if ($urandom_range(0, 39) == 0)
                drv_smooth = !drv_smooth;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pop results, stall in bursts, compare against rebuilt_q
    // ------------------------------------------------------------------
    int mon_idle   = 0;
    bit mon_smooth = 1'b0;

    task automatic check_result();
        res_t want;
        res_t got;
        got.out_byte     = out_byte;
        got.value_end    = value_end;
        got.empty_value  = empty_value;
        got.value_length = value_length;
        got.error_code   = err_t'(error_code);
        if (rebuilt_q.size() == 0)
        begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
                $display("%0t: unexpected result: byte %02h end %0b empty %0b len %0d err %0d",
                         $realtime, got.out_byte, got.value_end, got.empty_value,
                         got.value_length, got.error_code);
        end
        else
        begin
            want = rebuilt_q.pop_front();
            if (got.out_byte !== want.out_byte || got.value_end !== want.value_end ||
                got.empty_value !== want.empty_value ||
                got.value_length !== want.value_length ||
                got.error_code !== want.error_code)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                begin
                    $display("%0t: expected byte %02h end %0b empty %0b len %0d err %0d",
                             $realtime, want.out_byte, want.value_end, want.empty_value,
                             want.value_length, want.error_code);
                    $display("%0t:      got byte %02h end %0b empty %0b len %0d err %0d",
                             $realtime, got.out_byte, got.value_end, got.empty_value,
                             got.value_length, got.error_code);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            mon_idle = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result();

            if (mon_idle > 0)
            begin
                mon_idle--;
                pop <= 1'b0;
            end
            else if (!mon_smooth && coded_beats.size() > QUIET_TAIL &&
                     $urandom_range(0, 5) == 0)
            begin
                mon_idle = $urandom_range(0, 18);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;

            if ($urandom_range(0, 39) == 0)
                mon_smooth = !mon_smooth;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int p;
        int s;
        int k;
        int pick;
        int half;
        int waited;
        bit mid_drain_done;

        // Directed part: error codes, empty value, prefix-only value,
        // field extremes, ignored kind, restart in the middle of a value
        add_beat(KIND_RESTART, 0, 0, 0);
        add_header(1, 0);                       // prefix longer than nothing
        add_header(0, 0);                       // empty value
        add_beat(KIND_DATA, 0, 0, 8'h5A);       // byte with no value open
        add_beat(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_header(0, 3);
        add_beat(KIND_DATA, 0, 0, 8'h00);
        add_beat(KIND_DATA, 0, 0, 8'hFF);
        add_beat(KIND_DATA, 0, 0, 8'hA5);
        add_header(3, 0);                       // value made of the prefix alone
        add_header(2, 2);
        add_beat(KIND_DATA, 0, 0, 8'h3C);
        add_header(0, 0);                       // header while a value is open
        add_beat(KIND_DATA, 0, 0, 8'hC3);
        add_header(16'hFFFF, 16'hFFFF);         // prefix too long
        add_header(0, 16'hFFFF);                // value too long
        add_header(4, MAX_LEN - 3);             // one byte over MAX_LEN
        add_header(1, 2);
        add_beat(KIND_DATA, 0, 0, 8'h11);
        add_beat(KIND_RESTART, 0, 0, 0);        // abort the open value
        add_beat(KIND_DATA, 0, 0, 8'h22);       // now stray
        add_header(0, 0);
        gen_prev_len = 0;

        // Random part: mostly well-formed values, the rest broken or noise
        drain_pending  = 1'b1;
        half           = beat_total + RANDOM_BEATS / 2;
        mid_drain_done = 1'b0;
        while (beat_total < RANDOM_BEATS + 22)
        begin
            if (!mid_drain_done && beat_total >= half)
            begin
                drain_pending  = 1'b1;
                mid_drain_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                pick_value(p, s);
                add_value(p, s);
            end
            else if (pick < 75)
            begin
                add_beat(KIND_RESTART, $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 255));
                gen_prev_len = 0;
            end
            else if (pick < 80)
                add_bytes(1);
            else if (pick < 85)
                add_header($urandom_range(gen_prev_len + 1, 65535), $urandom_range(0, 65535));
            else if (pick < 90)
            begin
                p = $urandom_range(0, gen_prev_len);
                add_header(p, $urandom_range(MAX_LEN + 1 - p, 65535));
            end
            else if (pick < 95)
            begin
                // stray header lands inside a value; the value still completes
                pick_open_value(p, s);
                k = $urandom_range(0, s - 1);
                add_header(p, s);
                add_bytes(k);
                add_header($urandom_range(0, 65535), $urandom_range(0, 65535));
                add_bytes(s - k);
                gen_prev_len = p + s;
            end
            else if (pick < 98)
            begin
                pick_open_value(p, s);
                add_header(p, s);
                add_bytes($urandom_range(0, s - 1));
                add_beat(KIND_RESTART, 0, 0, 0);
                gen_prev_len = 0;
            end
            else
                add_beat(KIND_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 255));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last beat to be taken, then for the results to drain
        @(negedge clk);
        while (coded_beats.size() != 0 || push)
            @(negedge clk);
        waited = 0;
        while (rebuilt_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (rebuilt_q.size() != 0)
        begin
            $display("%0d expected results never arrived", rebuilt_q.size());
            fail_cnt += rebuilt_q.size();
        end

        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
